// ===== sv/drxfifo_pkg.sv =====
package drxfifo_pkg;

	// ring geometry
	localparam int DEPTH       = 1024;
	localparam int PACKET_SIZE = 64;
	localparam int PTR_W       = $clog2(DEPTH);
	localparam int MEM_DEPTH   = 2 * DEPTH;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);
	localparam int THRESH      = 2 * PACKET_SIZE;

	// field widths
	localparam int OP_W   = 2;
	localparam int LEN_W  = 7;
	localparam int BYTE_W = 8;
	localparam int FLOW_W = 2;
	localparam int FREE_W = 10;
	localparam int FREE_MAX = (1 << FREE_W) - 1;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 24;
	localparam int CFG_IDX_W = 1;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// operation codes
	localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
	localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// flow control actions
	localparam logic [FLOW_W-1:0] FLOW_NONE  = 2'd0;
	localparam logic [FLOW_W-1:0] FLOW_CLOSE = 2'd1;
	localparam logic [FLOW_W-1:0] FLOW_OPEN  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SKIP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK = 1'd1;

	// controller -> datapath commands
	typedef struct packed {
		logic accept; // latch the incoming beat
		logic exec;   // update pointers, write / read ring
		logic load;   // build result into output register
	} cmd_t;

	// free bytes of one ring, one entry always kept empty
	function automatic ptr_t free_of(input ptr_t wp, input ptr_t rp);
		ptr_t res;
		if (rp > wp) begin
			res = rp - wp - ptr_t'(1);
		end else begin
			res = ptr_t'(DEPTH - 1) - wp + rp;
		end
		return res;
	endfunction

	function automatic ptr_t ptr_inc(input ptr_t p);
		ptr_t res;
		if (p == ptr_t'(DEPTH - 1)) begin
			res = '0;
		end else begin
			res = p + ptr_t'(1);
		end
		return res;
	endfunction

endpackage

// ===== sv/drxfifo_ctrl.sv =====
module drxfifo_ctrl
	import drxfifo_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0] state_q;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd.accept = s_tvalid && s_tready;
		cmd.exec   = (state_q == ST_EXEC);
		cmd.load   = (state_q == ST_LOAD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/drxfifo_dp.sv =====
module drxfifo_dp
	import drxfifo_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tlast,
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tuser
);

	// config
	logic skip_q, block_q;

	// latched item
	logic [OP_W-1:0]   op_q;
	logic              ch_q;
	logic [LEN_W-1:0]  len_q;
	logic [BYTE_W-1:0] data_q;
	logic              last_q;

	// channel state
	ptr_t wp_q [2];
	ptr_t rp_q [2];
	logic drop_q [2];

	// ring memory
	logic [BYTE_W-1:0] mem [MEM_DEPTH];
	logic [BYTE_W-1:0] rd_q;

	// exec -> load flags
	logic valid_s1, lost_s1, dropped_s1, wasdrop_s1;

	// output register
	logic              rv_q;
	logic [BYTE_W-1:0] rdata_q;
	logic [FLOW_W-1:0] flow_q;
	logic              dropped_q, lost_q, empty_q;
	logic [FREE_W-1:0] free_q;

	ptr_t              wp_cur, rp_cur, wp_next, free_cur;
	logic              drop_cur, full_cur, empty_cur, below_cur, skip_hit;
	logic [LEN_W-1:0]  len_c;
	addr_t             addr_w, addr_r;
	logic [FLOW_W-1:0] flow_c;
	logic [FREE_W-1:0] free_sat;

	always_comb begin
		wp_cur    = wp_q[ch_q];
		rp_cur    = rp_q[ch_q];
		drop_cur  = drop_q[ch_q];
		wp_next   = ptr_inc(wp_cur);
		free_cur  = free_of(wp_cur, rp_cur);
		full_cur  = (wp_next == rp_cur);
		empty_cur = (wp_cur == rp_cur);
		below_cur = (free_cur < ptr_t'(THRESH));
		len_c     = (len_q > LEN_W'(PACKET_SIZE)) ? LEN_W'(PACKET_SIZE) : len_q;
		skip_hit  = skip_q && (ptr_t'(len_c) > free_cur);
		addr_w    = ch_q ? addr_t'(wp_cur) + addr_t'(DEPTH) : addr_t'(wp_cur);
		addr_r    = ch_q ? addr_t'(rp_cur) + addr_t'(DEPTH) : addr_t'(rp_cur);
	end

	// result flow action and saturated free count, from pointers already updated in exec
	always_comb begin
		flow_c = FLOW_NONE;
		case (op_q)
			OP_BEGIN: begin
				if (dropped_s1) begin
					flow_c = FLOW_OPEN;
				end else if (len_c == '0) begin
					flow_c = (block_q && below_cur) ? FLOW_CLOSE : FLOW_OPEN;
				end else begin
					flow_c = FLOW_CLOSE;
				end
			end
			OP_BYTE: begin
				if (!wasdrop_s1 && last_q) begin
					flow_c = (block_q && below_cur) ? FLOW_NONE : FLOW_OPEN;
				end
			end
			OP_READ: begin
				if (valid_s1 && !below_cur) flow_c = FLOW_OPEN;
			end
			default: begin
				flow_c = FLOW_NONE;
			end
		endcase
		if (int'(free_cur) > FREE_MAX) begin
			free_sat = FREE_W'(FREE_MAX);
		end else begin
			free_sat = FREE_W'(free_cur);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q  <= 1'b0;
			block_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SKIP:  skip_q  <= cfg_data;
				REG_BLOCK: block_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= s_tuser[1:0];
			ch_q   <= s_tuser[2];
			len_q  <= s_tdata[6:0];
			data_q <= s_tdata[14:7];
			last_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q[0]   <= '0;
			wp_q[1]   <= '0;
			rp_q[0]   <= '0;
			rp_q[1]   <= '0;
			drop_q[0] <= 1'b0;
			drop_q[1] <= 1'b0;
		end else if (cmd.exec) begin
			case (op_q)
				OP_BEGIN: drop_q[ch_q] <= skip_hit;
				OP_BYTE: begin
					if (drop_cur) begin
						if (last_q) drop_q[ch_q] <= 1'b0;
					end else if (!full_cur) begin
						wp_q[ch_q] <= wp_next;
					end
				end
				OP_READ: begin
					if (!empty_cur) rp_q[ch_q] <= ptr_inc(rp_cur);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			valid_s1   <= (op_q == OP_READ) && !empty_cur;
			lost_s1    <= (op_q == OP_BYTE) && (drop_cur || full_cur);
			dropped_s1 <= (op_q == OP_BEGIN) && skip_hit;
			wasdrop_s1 <= drop_cur;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && (op_q == OP_BYTE) && !drop_cur && !full_cur) begin
			mem[addr_w] <= data_q;
		end
		if (cmd.exec) begin
			rd_q <= mem[addr_r];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rv_q      <= valid_s1;
			rdata_q   <= valid_s1 ? rd_q : '0;
			flow_q    <= flow_c;
			dropped_q <= dropped_s1;
			lost_q    <= lost_s1;
			empty_q   <= empty_cur;
			free_q    <= free_sat;
		end
	end

	assign m_tuser = rv_q;
	assign m_tdata = {1'b0, free_q, empty_q, lost_q, dropped_q, flow_q, rdata_q};

endmodule

// ===== sv/dual_rx_fifo_flow_control.sv =====
// Result: the input beat is latched, exec updates the ring (registered read port), and load
// builds the result register, waiting until the output register is free.
// Items: one at a time; a new input beat is taken only in idle, after the previous load.
// Reset: arst_n asynchronous, active low; clears pointers, drop flags, config and
// handshake state. Ring contents are not cleared; entries are read only after written.
module dual_rx_fifo_flow_control
	import drxfifo_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // packet_length[6:0], data_byte[14:7], zero pad
	input  logic                 s_tlast,  // last_in_packet
	input  logic [S_TUSER_W-1:0] s_tuser,  // operation[1:0], channel[2]
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // read_data[7:0], flow_action[9:8],
	                                       // packet_dropped[10], byte_lost[11],
	                                       // channel_empty[12], free_space[22:13], pad
	output logic                 m_tuser,  // read_valid
	// config write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index, // 0 skip_mode, 1 block_mode
	input  logic                 cfg_data
);

	cmd_t cmd;

	// config always taken in one beat
	assign cfg_ready = 1'b1;

	// sequencer: idle -> exec -> load, result register decouples the output side
	drxfifo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// pointers, drop flags, ring memory and result build
	drxfifo_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
